@@ src/rpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

  localparam int POS_WIDTH_DEF = 51;
  localparam int VEL_WIDTH_DEF = 11;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX = 2'd1;

  localparam longint AREA_MIN_RESET = 64'sd200000000000000;
  localparam longint AREA_MAX_RESET = 64'sd400000000000000;

  typedef struct packed {
    logic par_space;
    logic par_plane;
    logic future;
  } rpc_flags_t;

endpackage

`default_nettype wire

@@ src/rpc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rpc_in_if #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = rpc_pkg::VEL_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] first_x;
  logic signed [POS_WIDTH-1:0] first_y;
  logic signed [POS_WIDTH-1:0] first_z;
  logic signed [VEL_WIDTH-1:0] first_vx;
  logic signed [VEL_WIDTH-1:0] first_vy;
  logic signed [VEL_WIDTH-1:0] first_vz;
  logic signed [POS_WIDTH-1:0] second_x;
  logic signed [POS_WIDTH-1:0] second_y;
  logic signed [POS_WIDTH-1:0] second_z;
  logic signed [VEL_WIDTH-1:0] second_vx;
  logic signed [VEL_WIDTH-1:0] second_vy;
  logic signed [VEL_WIDTH-1:0] second_vz;

  modport source (
    output valid, first_x, first_y, first_z, first_vx, first_vy, first_vz,
           second_x, second_y, second_z, second_vx, second_vy, second_vz,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, first_vx, first_vy, first_vz,
           second_x, second_y, second_z, second_vx, second_vy, second_vz,
    output ready
  );
endinterface

interface rpc_out_if;
  logic valid;
  logic ready;
  logic parallel_space;
  logic parallel_plane;
  logic both_future;
  logic inside_area;

  modport source (
    output valid, parallel_space, parallel_plane, both_future, inside_area,
    input  ready
  );
  modport sink (
    input  valid, parallel_space, parallel_plane, both_future, inside_area,
    output ready
  );
endinterface

interface rpc_cfg_if #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [rpc_pkg::CFG_IDX_W-1:0]  index;
  logic signed [POS_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/rpc_vel_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpc_vel_stage #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = rpc_pkg::VEL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [POS_WIDTH-1:0]   p1x,
  input  logic signed [POS_WIDTH-1:0]   p1y,
  input  logic signed [POS_WIDTH-1:0]   p2x,
  input  logic signed [POS_WIDTH-1:0]   p2y,
  input  logic signed [VEL_WIDTH-1:0]   v1x,
  input  logic signed [VEL_WIDTH-1:0]   v1y,
  input  logic signed [VEL_WIDTH-1:0]   v1z,
  input  logic signed [VEL_WIDTH-1:0]   v2x,
  input  logic signed [VEL_WIDTH-1:0]   v2y,
  input  logic signed [VEL_WIDTH-1:0]   v2z,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output rpc_pkg::rpc_flags_t           flags_o,
  output logic signed [2*VEL_WIDTH:0]   den_o,
  output logic signed [POS_WIDTH:0]     dx_o,
  output logic signed [POS_WIDTH:0]     dy_o,
  output logic signed [POS_WIDTH-1:0]   p1x_o,
  output logic signed [POS_WIDTH-1:0]   p1y_o,
  output logic signed [VEL_WIDTH-1:0]   v1x_o,
  output logic signed [VEL_WIDTH-1:0]   v1y_o,
  output logic signed [VEL_WIDTH-1:0]   v2x_o,
  output logic signed [VEL_WIDTH-1:0]   v2y_o
);
  import rpc_pkg::*;

  localparam int DW = 2 * VEL_WIDTH + 1;
  localparam int AW = POS_WIDTH + 1;

  logic                        valid_r;
  logic                        load;
  logic signed [DW-1:0]        den_nxt, cx, cy, den_r;
  logic signed [AW-1:0]        dx_nxt, dy_nxt, dx_r, dy_r;
  rpc_flags_t                  flags_nxt, flags_r;
  logic signed [POS_WIDTH-1:0] p1x_r, p1y_r;
  logic signed [VEL_WIDTH-1:0] v1x_r, v1y_r, v2x_r, v2y_r;

  assign den_nxt = DW'(v1x) * DW'(v2y) - DW'(v1y) * DW'(v2x);
  assign cx      = DW'(v1y) * DW'(v2z) - DW'(v1z) * DW'(v2y);
  assign cy      = DW'(v1z) * DW'(v2x) - DW'(v1x) * DW'(v2z);
  assign dx_nxt  = AW'(p2x) - AW'(p1x);
  assign dy_nxt  = AW'(p2y) - AW'(p1y);

  always_comb begin
    flags_nxt.par_plane = (den_nxt == '0);
    flags_nxt.par_space = flags_nxt.par_plane && (cx == '0) && (cy == '0);
    flags_nxt.future    = 1'b0;
  end

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      den_r   <= den_nxt;
      flags_r <= flags_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      p1x_r   <= p1x;
      p1y_r   <= p1y;
      v1x_r   <= v1x;
      v1y_r   <= v1y;
      v2x_r   <= v2x;
      v2y_r   <= v2y;
    end
  end

  assign dn_valid = valid_r;
  assign flags_o  = flags_r;
  assign den_o    = den_r;
  assign dx_o     = dx_r;
  assign dy_o     = dy_r;
  assign p1x_o    = p1x_r;
  assign p1y_o    = p1y_r;
  assign v1x_o    = v1x_r;
  assign v1y_o    = v1y_r;
  assign v2x_o    = v2x_r;
  assign v2y_o    = v2y_r;

endmodule

`default_nettype wire

@@ src/rpc_time_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpc_time_stage #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = rpc_pkg::VEL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  rpc_pkg::rpc_flags_t                 flags_i,
  input  logic signed [2*VEL_WIDTH:0]         den_i,
  input  logic signed [POS_WIDTH:0]           dx,
  input  logic signed [POS_WIDTH:0]           dy,
  input  logic signed [POS_WIDTH-1:0]         p1x,
  input  logic signed [POS_WIDTH-1:0]         p1y,
  input  logic signed [VEL_WIDTH-1:0]         v1x,
  input  logic signed [VEL_WIDTH-1:0]         v1y,
  input  logic signed [VEL_WIDTH-1:0]         v2x,
  input  logic signed [VEL_WIDTH-1:0]         v2y,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output rpc_pkg::rpc_flags_t                 flags_o,
  output logic signed [2*VEL_WIDTH:0]         den_o,
  output logic signed [POS_WIDTH+VEL_WIDTH+1:0] nt_o,
  output logic signed [POS_WIDTH-1:0]         p1x_o,
  output logic signed [POS_WIDTH-1:0]         p1y_o,
  output logic signed [VEL_WIDTH-1:0]         v1x_o,
  output logic signed [VEL_WIDTH-1:0]         v1y_o
);
  import rpc_pkg::*;

  localparam int DW = 2 * VEL_WIDTH + 1;
  localparam int NW = POS_WIDTH + VEL_WIDTH + 2;

  // stage a: time numerators
  logic                        a_valid_r, a_ready, a_load;
  logic signed [NW-1:0]        nt_a_nxt, ns_a_nxt, nt_a_r, ns_a_r;
  logic signed [DW-1:0]        den_a_r;
  rpc_flags_t                  flags_a_r;
  logic signed [POS_WIDTH-1:0] p1x_a_r, p1y_a_r;
  logic signed [VEL_WIDTH-1:0] v1x_a_r, v1y_a_r;

  // stage b: sign normalized to a non-negative denominator
  logic                        b_valid_r, b_load, neg;
  logic signed [NW-1:0]        nt_b_nxt, ns_b_nxt, nt_b_r;
  logic signed [DW-1:0]        den_b_nxt, den_b_r;
  rpc_flags_t                  flags_b_nxt, flags_b_r;
  logic signed [POS_WIDTH-1:0] p1x_b_r, p1y_b_r;
  logic signed [VEL_WIDTH-1:0] v1x_b_r, v1y_b_r;

  assign nt_a_nxt = NW'(dx) * NW'(v2y) - NW'(dy) * NW'(v2x);
  assign ns_a_nxt = NW'(dx) * NW'(v1y) - NW'(dy) * NW'(v1x);

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;
  assign a_load   = up_valid && up_ready;
  assign b_load   = a_valid_r && a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= up_valid;
      end
      if (a_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      nt_a_r    <= nt_a_nxt;
      ns_a_r    <= ns_a_nxt;
      den_a_r   <= den_i;
      flags_a_r <= flags_i;
      p1x_a_r   <= p1x;
      p1y_a_r   <= p1y;
      v1x_a_r   <= v1x;
      v1y_a_r   <= v1y;
    end
  end

  assign neg       = den_a_r[DW-1];
  assign den_b_nxt = neg ? -den_a_r : den_a_r;
  assign nt_b_nxt  = neg ? -nt_a_r : nt_a_r;
  assign ns_b_nxt  = neg ? -ns_a_r : ns_a_r;

  always_comb begin
    flags_b_nxt        = flags_a_r;
    flags_b_nxt.future = !flags_a_r.par_plane && !nt_b_nxt[NW-1] && !ns_b_nxt[NW-1];
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      nt_b_r    <= nt_b_nxt;
      den_b_r   <= den_b_nxt;
      flags_b_r <= flags_b_nxt;
      p1x_b_r   <= p1x_a_r;
      p1y_b_r   <= p1y_a_r;
      v1x_b_r   <= v1x_a_r;
      v1y_b_r   <= v1y_a_r;
    end
  end

  assign dn_valid = b_valid_r;
  assign flags_o  = flags_b_r;
  assign den_o    = den_b_r;
  assign nt_o     = nt_b_r;
  assign p1x_o    = p1x_b_r;
  assign p1y_o    = p1y_b_r;
  assign v1x_o    = v1x_b_r;
  assign v1y_o    = v1y_b_r;

endmodule

`default_nettype wire

@@ src/rpc_area_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpc_area_stage #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = rpc_pkg::VEL_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  rpc_pkg::rpc_flags_t                   flags_i,
  input  logic signed [2*VEL_WIDTH:0]           den,
  input  logic signed [POS_WIDTH+VEL_WIDTH+1:0] nt,
  input  logic signed [POS_WIDTH-1:0]           p1x,
  input  logic signed [POS_WIDTH-1:0]           p1y,
  input  logic signed [VEL_WIDTH-1:0]           v1x,
  input  logic signed [VEL_WIDTH-1:0]           v1y,
  input  logic signed [POS_WIDTH-1:0]           area_min,
  input  logic signed [POS_WIDTH-1:0]           area_max,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic                                  parallel_space,
  output logic                                  parallel_plane,
  output logic                                  both_future,
  output logic                                  inside_area
);
  import rpc_pkg::*;

  localparam int XW = POS_WIDTH + 2 * VEL_WIDTH + 4;

  // stage a: products scaled by the denominator
  logic                 a_valid_r, a_ready, a_load;
  logic signed [XW-1:0] px_r, tx_r, py_r, ty_r, lo_r, hi_r;
  rpc_flags_t           flags_a_r;

  // stage b: sums and bound compares, result register
  logic                 b_valid_r, b_load, inside_nxt;
  logic signed [XW-1:0] xs, ys;
  logic                 par_space_r, par_plane_r, future_r, inside_r;

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;
  assign a_load   = up_valid && up_ready;
  assign b_load   = a_valid_r && a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= up_valid;
      end
      if (a_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      px_r      <= XW'(p1x) * XW'(den);
      tx_r      <= XW'(nt) * XW'(v1x);
      py_r      <= XW'(p1y) * XW'(den);
      ty_r      <= XW'(nt) * XW'(v1y);
      lo_r      <= XW'(area_min) * XW'(den);
      hi_r      <= XW'(area_max) * XW'(den);
      flags_a_r <= flags_i;
    end
  end

  assign xs = px_r + tx_r;
  assign ys = py_r + ty_r;
  assign inside_nxt = flags_a_r.future && (lo_r <= xs) && (xs <= hi_r) &&
                      (lo_r <= ys) && (ys <= hi_r);

  always_ff @(posedge clk) begin
    if (b_load) begin
      par_space_r <= flags_a_r.par_space;
      par_plane_r <= flags_a_r.par_plane;
      future_r    <= flags_a_r.future;
      inside_r    <= inside_nxt;
    end
  end

  assign dn_valid       = b_valid_r;
  assign parallel_space = par_space_r;
  assign parallel_plane = par_plane_r;
  assign both_future    = future_r;
  assign inside_area    = inside_r;

endmodule

`default_nettype wire

@@ src/ray_pair_crossing_in_area.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir   Handshake          Payload
// in_ch     in    valid / ready      first_{x,y,z,vx,vy,vz}, second_{x,y,z,vx,vy,vz}
// out_ch    out   valid / ready      parallel_space, parallel_plane, both_future, inside_area
// cfg_ch    in    valid / ready      index (0 area_min, 1 area_max), data
//
// One item per cycle unless out_ch stalls; five register stages lie between an
// accepted item and its result on out_ch.
// Stages: velocity cross products, time numerators, sign fix, scaled point
// products, sums and bound compares into the output register.
// Each stage holds its item while the next one is full and stalled; empty stages still fill.
// Synchronous reset empties the pipeline and loads the default square.
// cfg_ch.ready is always high; unknown indexes are dropped.

module ray_pair_crossing_in_area #(
  parameter int POS_WIDTH = rpc_pkg::POS_WIDTH_DEF,
  parameter int VEL_WIDTH = rpc_pkg::VEL_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rpc_in_if.sink   in_ch,
  rpc_out_if.source out_ch,
  rpc_cfg_if.sink  cfg_ch
);
  import rpc_pkg::*;

  localparam int DW = 2 * VEL_WIDTH + 1;
  localparam int NW = POS_WIDTH + VEL_WIDTH + 2;

  logic signed [POS_WIDTH-1:0] area_min_r, area_max_r;

  logic                        s1_valid, s1_ready;
  rpc_flags_t                  s1_flags;
  logic signed [DW-1:0]        s1_den;
  logic signed [POS_WIDTH:0]   s1_dx, s1_dy;
  logic signed [POS_WIDTH-1:0] s1_p1x, s1_p1y;
  logic signed [VEL_WIDTH-1:0] s1_v1x, s1_v1y, s1_v2x, s1_v2y;

  logic                        s3_valid, s3_ready;
  rpc_flags_t                  s3_flags;
  logic signed [DW-1:0]        s3_den;
  logic signed [NW-1:0]        s3_nt;
  logic signed [POS_WIDTH-1:0] s3_p1x, s3_p1y;
  logic signed [VEL_WIDTH-1:0] s3_v1x, s3_v1y;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_min_r <= POS_WIDTH'(AREA_MIN_RESET);
      area_max_r <= POS_WIDTH'(AREA_MAX_RESET);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_AREA_MIN: area_min_r <= cfg_ch.data;
        REG_AREA_MAX: area_max_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  rpc_vel_stage #(
    .POS_WIDTH (POS_WIDTH),
    .VEL_WIDTH (VEL_WIDTH)
  ) u_vel (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .p1x      (in_ch.first_x),
    .p1y      (in_ch.first_y),
    .p2x      (in_ch.second_x),
    .p2y      (in_ch.second_y),
    .v1x      (in_ch.first_vx),
    .v1y      (in_ch.first_vy),
    .v1z      (in_ch.first_vz),
    .v2x      (in_ch.second_vx),
    .v2y      (in_ch.second_vy),
    .v2z      (in_ch.second_vz),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .flags_o  (s1_flags),
    .den_o    (s1_den),
    .dx_o     (s1_dx),
    .dy_o     (s1_dy),
    .p1x_o    (s1_p1x),
    .p1y_o    (s1_p1y),
    .v1x_o    (s1_v1x),
    .v1y_o    (s1_v1y),
    .v2x_o    (s1_v2x),
    .v2y_o    (s1_v2y)
  );

  rpc_time_stage #(
    .POS_WIDTH (POS_WIDTH),
    .VEL_WIDTH (VEL_WIDTH)
  ) u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .flags_i  (s1_flags),
    .den_i    (s1_den),
    .dx       (s1_dx),
    .dy       (s1_dy),
    .p1x      (s1_p1x),
    .p1y      (s1_p1y),
    .v1x      (s1_v1x),
    .v1y      (s1_v1y),
    .v2x      (s1_v2x),
    .v2y      (s1_v2y),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .flags_o  (s3_flags),
    .den_o    (s3_den),
    .nt_o     (s3_nt),
    .p1x_o    (s3_p1x),
    .p1y_o    (s3_p1y),
    .v1x_o    (s3_v1x),
    .v1y_o    (s3_v1y)
  );

  rpc_area_stage #(
    .POS_WIDTH (POS_WIDTH),
    .VEL_WIDTH (VEL_WIDTH)
  ) u_area (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (s3_valid),
    .up_ready       (s3_ready),
    .flags_i        (s3_flags),
    .den            (s3_den),
    .nt             (s3_nt),
    .p1x            (s3_p1x),
    .p1y            (s3_p1y),
    .v1x            (s3_v1x),
    .v1y            (s3_v1y),
    .area_min       (area_min_r),
    .area_max       (area_max_r),
    .dn_valid       (out_ch.valid),
    .dn_ready       (out_ch.ready),
    .parallel_space (out_ch.parallel_space),
    .parallel_plane (out_ch.parallel_plane),
    .both_future    (out_ch.both_future),
    .inside_area    (out_ch.inside_area)
  );

endmodule

`default_nettype wire

@@ src/rpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic parallel_space,
  input logic parallel_plane,
  input logic both_future,
  input logic inside_area
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_space_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && parallel_space |-> parallel_plane)
    else $error("parallel in 3D but not in plane");

  a_future_needs_crossing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && both_future |-> !parallel_plane)
    else $error("future crossing on plane-parallel pair");

  a_inside_needs_future: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_area |-> both_future)
    else $error("inside area without future crossing");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(parallel_space) &&
      $stable(parallel_plane) && $stable(both_future) && $stable(inside_area))
    else $error("stalled result changed");

endmodule

bind ray_pair_crossing_in_area rpc_checker u_rpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .parallel_space (out_ch.parallel_space),
  .parallel_plane (out_ch.parallel_plane),
  .both_future    (out_ch.both_future),
  .inside_area    (out_ch.inside_area)
);

`default_nettype wire
